>>> design/tlsevc_pkg.sv
// Package for the TLS extension vector checker.
// Holds the result outcome codes, the result record and the size of the bucket bitmap.
// It has no dependencies.
package tlsevc_pkg;

  localparam int BUCKETS = 256;

  typedef enum logic [2:0] {
    OC_EXT   = 3'd0,
    OC_DONE  = 3'd1,
    OC_TRUNC = 3'd2,
    OC_DUP   = 3'd3,
    OC_FULL  = 3'd4
  } outcome_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [15:0] ext_type;
    logic [15:0] ext_length;
    logic [15:0] ext_offset;
    logic        last;
  } result_t;

endpackage

>>> design/tls_extension_vector_checker.sv
// Flow: an accepted beat is held and parsed in S_PROC; a beat that closes an entry goes on to
// the bucket bitmap check in S_CHECK, and a bitmap hit walks the stored types, one read and one
// compare per type, until a match or the end of the table. Each result, also a done or truncated
// one on a last beat, is loaded into the output register in S_EMIT. in_tready is low from
// acceptance until the beat is fully handled, so a new beat is taken only after the last one.
// Reset (sync, rst_n low): parser idle, bitmap and count cleared, output empty; no table clear.
module tls_extension_vector_checker
  import tlsevc_pkg::*;
#(
  parameter int MAX_EXTENSIONS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream: at most one vector byte per beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] ext_type, [31:16] ext_length, [47:32] ext_offset
  output logic [2:0]  out_tuser,  // [2:0] outcome
  output logic        out_tlast   // final_result
);

  localparam int CNT_W = $clog2(MAX_EXTENSIONS + 1);
  localparam int IDX_W = (MAX_EXTENSIONS > 1) ? $clog2(MAX_EXTENSIONS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROC,      // parse the held byte
    S_CHECK,     // bucket bitmap lookup on entry completion
    S_WALK_RD,   // read one stored type
    S_WALK_CMP,  // compare it against the held type
    S_EMIT       // load a result into the output register
  } state_t;

  typedef enum logic [2:0] {
    PH_TYPE_HI,
    PH_TYPE_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY
  } phase_t;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [15:0]        type_r, type_nxt;
  logic [15:0]        body_r, body_nxt;
  logic [15:0]        pos_r, pos_nxt;
  logic [15:0]        start_r, start_nxt;
  logic               err_r, err_nxt;
  logic [BUCKETS-1:0] bitmap_r, bitmap_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   walk_r, walk_nxt;

  // held input beat
  logic [7:0]         byte_r, byte_nxt;
  logic               hb_r, hb_nxt;
  logic               lb_r, lb_nxt;

  // pending result, and a done result still owed after it
  result_t            res_r, res_nxt;
  logic               tail_r, tail_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r, out_nxt;

  // type table
  logic [15:0]        table_mem [MAX_EXTENSIONS];
  logic [15:0]        rd_data_r;
  logic               mem_we;
  logic               mem_re;

  logic               done;
  logic               fin_go;
  logic               fin_dup;
  logic               out_free;
  logic [15:0]        entry_len;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.ext_offset, out_r.ext_length, out_r.ext_type};
  assign out_tuser  = out_r.outcome;
  assign out_tlast  = out_r.last;

  assign out_free  = !out_valid_r || out_tready;
  assign entry_len = 16'(pos_r - start_r - 16'd4);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    type_nxt      = type_r;
    body_nxt      = body_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    err_nxt       = err_r;
    bitmap_nxt    = bitmap_r;
    count_nxt     = count_r;
    walk_nxt      = walk_r;
    byte_nxt      = byte_r;
    hb_nxt        = hb_r;
    lb_nxt        = lb_r;
    res_nxt       = res_r;
    tail_nxt      = tail_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    done          = 1'b0;
    fin_go        = 1'b0;
    fin_dup       = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          byte_nxt  = in_tdata;
          hb_nxt    = in_tuser;
          lb_nxt    = in_tlast;
          state_nxt = S_PROC;
        end
      end

      S_PROC: begin
        state_nxt = S_IDLE;
        if (err_r) begin
          // swallow everything up to the end of the vector
          if (lb_r) begin
            phase_nxt  = PH_TYPE_HI;
            type_nxt   = '0;
            body_nxt   = '0;
            pos_nxt    = '0;
            start_nxt  = '0;
            err_nxt    = 1'b0;
            bitmap_nxt = '0;
            count_nxt  = '0;
          end
        end else begin
          if (hb_r) begin
            case (phase_r)
              PH_TYPE_HI: begin
                start_nxt = pos_r;
                type_nxt  = {byte_r, 8'h00};
                phase_nxt = PH_TYPE_LO;
              end
              PH_TYPE_LO: begin
                type_nxt  = {type_r[15:8], byte_r};
                phase_nxt = PH_LEN_HI;
              end
              PH_LEN_HI: begin
                body_nxt  = {byte_r, 8'h00};
                phase_nxt = PH_LEN_LO;
              end
              PH_LEN_LO: begin
                body_nxt  = {body_r[15:8], byte_r};
                phase_nxt = PH_BODY;
                done      = ({body_r[15:8], byte_r} == 16'd0);
              end
              default: begin
                body_nxt = 16'(body_r - 16'd1);
                done     = (body_r == 16'd1);
              end
            endcase
            pos_nxt = 16'(pos_r + 16'd1);
          end
          if (done) begin
            state_nxt = S_CHECK;
          end else if (lb_r) begin
            // vector ends here: done on an entry boundary, else truncated
            res_nxt.ext_length = '0;
            res_nxt.last       = 1'b1;
            if (phase_nxt == PH_TYPE_HI) begin
              res_nxt.outcome    = OC_DONE;
              res_nxt.ext_type   = '0;
              res_nxt.ext_offset = pos_nxt;
            end else begin
              res_nxt.outcome    = OC_TRUNC;
              res_nxt.ext_type   = (phase_nxt == PH_TYPE_LO) ? 16'd0 : type_nxt;
              res_nxt.ext_offset = start_nxt;
            end
            tail_nxt   = 1'b0;
            phase_nxt  = PH_TYPE_HI;
            type_nxt   = '0;
            body_nxt   = '0;
            pos_nxt    = '0;
            start_nxt  = '0;
            bitmap_nxt = '0;
            count_nxt  = '0;
            state_nxt  = S_EMIT;
          end
        end
      end

      S_CHECK: begin
        if (bitmap_r[type_r[7:0]]) begin
          walk_nxt  = '0;
          state_nxt = S_WALK_RD;
        end else begin
          fin_go = 1'b1;
        end
      end

      S_WALK_RD: begin
        if (walk_r >= count_r) begin
          fin_go = 1'b1;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_WALK_CMP;
        end
      end

      S_WALK_CMP: begin
        if (rd_data_r == type_r) begin
          fin_go  = 1'b1;
          fin_dup = 1'b1;
        end else begin
          walk_nxt  = CNT_W'(walk_r + 1'b1);
          state_nxt = S_WALK_RD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          if (tail_r) begin
            // entry closed on the last beat: done follows
            res_nxt.outcome    = OC_DONE;
            res_nxt.ext_type   = '0;
            res_nxt.ext_length = '0;
            res_nxt.ext_offset = pos_r;
            res_nxt.last       = 1'b1;
            tail_nxt   = 1'b0;
            phase_nxt  = PH_TYPE_HI;
            type_nxt   = '0;
            body_nxt   = '0;
            pos_nxt    = '0;
            start_nxt  = '0;
            bitmap_nxt = '0;
            count_nxt  = '0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // close the entry held in type_r
    if (fin_go) begin
      phase_nxt          = PH_TYPE_HI;
      res_nxt.ext_type   = type_r;
      res_nxt.ext_length = entry_len;
      res_nxt.ext_offset = start_r;
      state_nxt          = S_EMIT;
      if (fin_dup || count_r >= CNT_W'(MAX_EXTENSIONS)) begin
        res_nxt.outcome = fin_dup ? OC_DUP : OC_FULL;
        res_nxt.last    = 1'b1;
        tail_nxt        = 1'b0;
        err_nxt         = 1'b1;
        if (lb_r) begin
          // error on the last beat ends the vector silently
          type_nxt   = '0;
          body_nxt   = '0;
          pos_nxt    = '0;
          start_nxt  = '0;
          err_nxt    = 1'b0;
          bitmap_nxt = '0;
          count_nxt  = '0;
        end
      end else begin
        res_nxt.outcome             = OC_EXT;
        res_nxt.last                = 1'b0;
        tail_nxt                    = lb_r;
        mem_we                      = 1'b1;
        bitmap_nxt[type_r[7:0]]     = 1'b1;
        count_nxt                   = CNT_W'(count_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_TYPE_HI;
      type_r      <= '0;
      body_r      <= '0;
      pos_r       <= '0;
      start_r     <= '0;
      err_r       <= 1'b0;
      bitmap_r    <= '0;
      count_r     <= '0;
      walk_r      <= '0;
      tail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      type_r      <= type_nxt;
      body_r      <= body_nxt;
      pos_r       <= pos_nxt;
      start_r     <= start_nxt;
      err_r       <= err_nxt;
      bitmap_r    <= bitmap_nxt;
      count_r     <= count_nxt;
      walk_r      <= walk_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    hb_r   <= hb_nxt;
    lb_r   <= lb_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // type table: one write port, one registered read port; a write and a read never fall in the same cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[count_r[IDX_W-1:0]] <= type_r;
    end
    if (mem_re) begin
      rd_data_r <= table_mem[walk_r[IDX_W-1:0]];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_EXTENSIONS))
    else $error("stored type count beyond table size");

  a_empty_bitmap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (bitmap_r == '0))
    else $error("bucket bit set with no stored types");

  a_walk_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK_RD || state_r == S_WALK_CMP) |-> !err_r)
    else $error("table walk while an error is latched");

  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.outcome == OC_DUP || out_r.outcome == OC_FULL)) |-> out_r.last)
    else $error("error result not marked final");
`endif

endmodule
